/* rtl/core/can_adapter_frame_parser_defines.svh */
// assertion macros for the frame parser
`ifndef CAN_ADAPTER_FRAME_PARSER_DEFINES_SVH
`define CAN_ADAPTER_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define CAFP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CAFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CAFP_ASSERT_IMP(label, clk, rst, ante, cons)
`define CAFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/cafp_pkg.sv */
package cafp_pkg;

   localparam logic [4:0] POS_HUNT  = 5'd0;
   localparam logic [4:0] POS_SYNC1 = 5'd1;
   localparam logic [4:0] POS_HDR2  = 5'd2;
   localparam logic [4:0] POS_HDR3  = 5'd3;
   localparam logic [4:0] POS_HDR4  = 5'd4;
   localparam logic [4:0] POS_ID0   = 5'd5;
   localparam logic [4:0] POS_ID3   = 5'd8;
   localparam logic [4:0] POS_LEN   = 5'd9;
   localparam logic [4:0] POS_DATA0 = 5'd10;
   localparam logic [4:0] POS_DATA7 = 5'd17;
   localparam logic [4:0] POS_PAD   = 5'd18;
   localparam logic [4:0] POS_CHECK = 5'd19;

   localparam logic [7:0] HDR_BYTE0 = 8'hAA;
   localparam logic [7:0] HDR_BYTE1 = 8'h55;
   localparam logic [7:0] HDR_BYTE2 = 8'h01;
   localparam logic [7:0] HDR_BYTE3 = 8'h02;
   localparam logic [7:0] HDR_BYTE4 = 8'h01;

   localparam logic [3:0] NIB_MESSAGE = 4'h0;
   localparam logic [3:0] NIB_SIGNAL  = 4'h1;
   localparam logic [3:0] MAX_LENGTH  = 4'd8;

   typedef struct packed {
      logic        frame_kind;
      logic [3:0]  command;
      logic [11:0] sender;
      logic [11:0] target;
      logic [15:0] signal_number;
      logic [3:0]  payload_length;
      logic [63:0] payload;
   } result_type;

endpackage

/* rtl/core/cafp_if.sv */
interface cafp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cafp_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_kind;
   logic [3:0]  command;
   logic [11:0] sender;
   logic [11:0] target;
   logic [15:0] signal_number;
   logic [3:0]  payload_length;
   logic [63:0] payload;

   modport source (output valid, output frame_kind, output command, output sender,
                   output target, output signal_number, output payload_length,
                   output payload, input ready);
   modport sink (input valid, input frame_kind, input command, input sender,
                 input target, input signal_number, input payload_length,
                 input payload, output ready);
endinterface

/* rtl/core/cafp_decode.sv */
module cafp_decode (
   input  logic [31:0]         identifier,
   input  logic [7:0]          length_byte,
   input  logic [63:0]         payload_store,
   output logic                keep,
   output cafp_pkg::result_type result
);
   import cafp_pkg::*;

   logic [3:0] nib;
   logic [3:0] len;

   assign nib = identifier[31:28];

   always_comb begin
      keep = (nib == NIB_MESSAGE) || (nib == NIB_SIGNAL);
      len  = (length_byte > 8'(MAX_LENGTH)) ? MAX_LENGTH : length_byte[3:0];

      result = '0;
      result.payload_length = len;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < len) begin
            result.payload[8*i +: 8] = payload_store[8*i +: 8];
         end
      end

      if (nib == NIB_SIGNAL) begin
         result.frame_kind    = 1'b1;
         result.signal_number = identifier[27:12];
      end else begin
         result.frame_kind = 1'b0;
         result.command    = identifier[27:24];
         result.sender     = identifier[23:12];
         result.target     = identifier[11:0];
      end
   end

endmodule

/* rtl/core/can_adapter_frame_parser.sv */
// can adapter frame parser
// req_ch carries one received serial byte per request (rx_byte); rsp_ch carries
// one decoded frame per request: kind, command, sender, target, signal number,
// saturated payload length and the masked payload bytes.
// the parser hunts for header AA 55 01 02 01, collects identifier, length and
// eight data bytes, checks the pad byte and the additive checksum, and emits a
// response only for good frames whose identifier top nibble is 0 or 1.
// throughput: one byte per cycle while req_ch is ready; the byte-wise
// position/sum update is a single register stage.
// latency: the response is valid the cycle after the checksum byte is taken.
// when rsp_ch stalls, the response register holds; req_ch stays ready as long as
// the response register is empty or being drained this cycle, so at most one
// response waits.
// reset (synchronous, active high) returns the parser to hunting and drops any
// pending response.
`include "can_adapter_frame_parser_defines.svh"

module can_adapter_frame_parser (
   input logic         clock,
   input logic         reset,
   cafp_req_if.sink    req_ch,
   cafp_rsp_if.source  rsp_ch
);
   import cafp_pkg::*;

   logic [4:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic [31:0] id_ff, id_in;
   logic [7:0]  len_ff, len_in;
   logic [63:0] data_ff, data_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;

   logic        in_fire;
   logic        emit;
   logic        keep;
   result_type  dec_result;
   logic [7:0]  d;
   logic [1:0]  id_sel;
   logic [2:0]  data_sel;

   assign d        = req_ch.rx_byte;
   assign req_ch.ready = !out_valid_ff || rsp_ch.ready;
   assign in_fire  = req_ch.valid && req_ch.ready;
   assign id_sel   = 2'(pos_ff - POS_ID0);
   assign data_sel = 3'(pos_ff - POS_DATA0);

   cafp_decode u_decode (
      .identifier    (id_ff),
      .length_byte   (len_ff),
      .payload_store (data_ff),
      .keep          (keep),
      .result        (dec_result)
   );

   always_comb begin
      pos_in  = pos_ff;
      sum_in  = sum_ff;
      id_in   = id_ff;
      len_in  = len_ff;
      data_in = data_ff;
      emit    = 1'b0;
      if (in_fire) begin
         case (pos_ff) inside
            POS_HUNT: begin
               if (d == HDR_BYTE0) pos_in = POS_SYNC1;
            end
            POS_SYNC1: begin
               sum_in = '0;
               pos_in = (d == HDR_BYTE1) ? POS_HDR2 : POS_HUNT;
            end
            POS_HDR2: begin
               sum_in = sum_ff + d;
               pos_in = (d == HDR_BYTE2) ? POS_HDR3 : POS_HUNT;
            end
            POS_HDR3: begin
               sum_in = sum_ff + d;
               pos_in = (d == HDR_BYTE3) ? POS_HDR4 : POS_HUNT;
            end
            POS_HDR4: begin
               sum_in = sum_ff + d;
               pos_in = (d == HDR_BYTE4) ? POS_ID0 : POS_HUNT;
            end
            [POS_ID0:POS_ID3]: begin
               sum_in = sum_ff + d;
               id_in[{id_sel, 3'b000} +: 8] = d;
               pos_in = pos_ff + 5'd1;
            end
            POS_LEN: begin
               sum_in = sum_ff + d;
               len_in = d;
               pos_in = POS_DATA0;
            end
            [POS_DATA0:POS_DATA7]: begin
               sum_in = sum_ff + d;
               data_in[{data_sel, 3'b000} +: 8] = d;
               pos_in = pos_ff + 5'd1;
            end
            POS_PAD: begin
               sum_in = sum_ff + d;
               pos_in = (d == 8'd0) ? POS_CHECK : POS_HUNT;
            end
            POS_CHECK: begin
               pos_in = POS_HUNT;
               emit   = (d == sum_ff) && keep;
            end
            default: begin
               pos_in = POS_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_in       = dec_result;
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_HUNT;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
      id_ff   <= id_in;
      len_ff  <= len_in;
      data_ff <= data_in;
      out_ff  <= out_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.frame_kind     = out_ff.frame_kind;
   assign rsp_ch.command        = out_ff.command;
   assign rsp_ch.sender         = out_ff.sender;
   assign rsp_ch.target         = out_ff.target;
   assign rsp_ch.signal_number  = out_ff.signal_number;
   assign rsp_ch.payload_length = out_ff.payload_length;
   assign rsp_ch.payload        = out_ff.payload;

   `CAFP_ASSERT_IMP(a_pos_range, clock, reset, 1'b1, pos_ff <= POS_CHECK)
   `CAFP_ASSERT_NEXT(a_pos_hold, clock, reset, !in_fire, $stable(pos_ff))
   `CAFP_ASSERT_IMP(a_rsp_origin, clock, reset, $rose(out_valid_ff),
                    $past(in_fire) && $past(pos_ff) == POS_CHECK)

endmodule

/* verif/can_adapter_frame_parser_tb.sv */
module can_adapter_frame_parser_tb;
   import cafp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 150;
   localparam int DRAIN_WAIT  = 8;

   typedef logic [19:0][7:0] frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cafp_req_if req_ch ();
   cafp_rsp_if rsp_ch ();

   can_adapter_frame_parser i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [4:0]  parse_pos    = POS_HUNT;
   logic [7:0]  checksum_acc = '0;
   logic [31:0] ident_acc    = '0;
   logic [7:0]  length_acc   = '0;
   logic [63:0] data_acc     = '0;

   result_type expected_frames [$];

   int error_count   = 0;
   int bytes_sent    = 0;
   int results_seen  = 0;
   int cycle_count   = 0;
   int hold_requests = 0;
   bit req_gaps_on   = 1'b0;
   bit rsp_stalls_on = 1'b0;

   function automatic void parse_byte(input logic [7:0] d);
      int         sh;
      logic [7:0] hdr;
      logic [3:0] len;
      result_type r;
      if (parse_pos == POS_HUNT) begin
         if (d == HDR_BYTE0) parse_pos = POS_SYNC1;
      end else if (parse_pos == POS_SYNC1) begin
         checksum_acc = '0;
         parse_pos = (d == HDR_BYTE1) ? POS_HDR2 : POS_HUNT;
      end else if (parse_pos <= POS_HDR4) begin
         checksum_acc = checksum_acc + d;
         hdr = (parse_pos == POS_HDR2) ? HDR_BYTE2 :
               (parse_pos == POS_HDR3) ? HDR_BYTE3 : HDR_BYTE4;
         parse_pos = (d == hdr) ? parse_pos + 5'd1 : POS_HUNT;
      end else if (parse_pos <= POS_ID3) begin
         checksum_acc = checksum_acc + d;
         if (parse_pos == POS_ID0) ident_acc = '0;
         sh = (int'(parse_pos) - int'(POS_ID0)) * 8;
         ident_acc[sh +: 8] = d;
         parse_pos = parse_pos + 5'd1;
      end else if (parse_pos == POS_LEN) begin
         checksum_acc = checksum_acc + d;
         length_acc = d;
         data_acc = '0;
         parse_pos = POS_DATA0;
      end else if (parse_pos <= POS_DATA7) begin
         checksum_acc = checksum_acc + d;
         sh = (int'(parse_pos) - int'(POS_DATA0)) * 8;
         data_acc[sh +: 8] = d;
         parse_pos = parse_pos + 5'd1;
      end else if (parse_pos == POS_PAD) begin
         checksum_acc = checksum_acc + d;
         parse_pos = (d == 8'h00) ? POS_CHECK : POS_HUNT;
      end else if (parse_pos == POS_CHECK) begin
         parse_pos = POS_HUNT;
         if (d == checksum_acc &&
             (ident_acc[31:28] == NIB_MESSAGE || ident_acc[31:28] == NIB_SIGNAL)) begin
            r = '0;
            len = (length_acc > 8'(MAX_LENGTH)) ? MAX_LENGTH : length_acc[3:0];
            if (ident_acc[31:28] == NIB_MESSAGE) begin
               r.frame_kind = 1'b0;
               r.command    = ident_acc[27:24];
               r.sender     = ident_acc[23:12];
               r.target     = ident_acc[11:0];
            end else begin
               r.frame_kind    = 1'b1;
               r.signal_number = ident_acc[27:12];
            end
            r.payload_length = len;
            for (int k = 0; k < 8; k++) begin
               if (k < int'(len)) r.payload[k*8 +: 8] = data_acc[k*8 +: 8];
            end
            expected_frames.push_back(r);
         end
      end else begin
         parse_pos = POS_HUNT;
      end
   endfunction

   task automatic check_frame(input result_type want, input result_type got);
      if (got.frame_kind !== want.frame_kind) begin
         $error("frame_kind expected %0h actual %0h", want.frame_kind, got.frame_kind);
         error_count++;
      end
      if (got.command !== want.command) begin
         $error("command expected %0h actual %0h", want.command, got.command);
         error_count++;
      end
      if (got.sender !== want.sender) begin
         $error("sender expected %0h actual %0h", want.sender, got.sender);
         error_count++;
      end
      if (got.target !== want.target) begin
         $error("target expected %0h actual %0h", want.target, got.target);
         error_count++;
      end
      if (got.signal_number !== want.signal_number) begin
         $error("signal_number expected %0h actual %0h", want.signal_number,
                got.signal_number);
         error_count++;
      end
      if (got.payload_length !== want.payload_length) begin
         $error("payload_length expected %0h actual %0h", want.payload_length,
                got.payload_length);
         error_count++;
      end
      if (got.payload !== want.payload) begin
         $error("payload expected %h actual %h", want.payload, got.payload);
         error_count++;
      end
   endtask

   // request and result monitor
   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) parse_byte(req_ch.rx_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.frame_kind     = rsp_ch.frame_kind;
            got.command        = rsp_ch.command;
            got.sender         = rsp_ch.sender;
            got.target         = rsp_ch.target;
            got.signal_number  = rsp_ch.signal_number;
            got.payload_length = rsp_ch.payload_length;
            got.payload        = rsp_ch.payload;
            results_seen++;
            if (expected_frames.size() == 0) begin
               $error("unexpected result kind %0h length %0h", got.frame_kind,
                      got.payload_length);
               error_count++;
            end else begin
               check_frame(expected_frames.pop_front(), got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL can_adapter_frame_parser");
         $finish;
      end
   end

   // result receiver
   initial begin
      int seen;
      int hold_left;
      int stall_left;
      seen = 0;
      hold_left = 0;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != seen) begin
            seen = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input frame_type f);
      for (int k = 0; k < 20; k++) send_byte(f[k]);
   endtask

   function automatic frame_type make_frame(input logic [31:0] id, input logic [7:0] len,
                                            input logic [63:0] data);
      frame_type  f;
      logic [7:0] acc;
      f[0] = HDR_BYTE0;
      f[1] = HDR_BYTE1;
      f[2] = HDR_BYTE2;
      f[3] = HDR_BYTE3;
      f[4] = HDR_BYTE4;
      for (int k = 0; k < 4; k++) f[5+k] = id[k*8 +: 8];
      f[9] = len;
      for (int k = 0; k < 8; k++) f[10+k] = data[k*8 +: 8];
      f[18] = 8'h00;
      acc = '0;
      for (int k = 2; k <= 18; k++) acc = acc + f[k];
      f[19] = acc;
      return f;
   endfunction

   function automatic logic [31:0] random_ident();
      int         pick;
      logic [3:0] nib;
      pick = $urandom_range(0, 99);
      nib = (pick < 45) ? NIB_MESSAGE : (pick < 90) ? NIB_SIGNAL : 4'($urandom_range(2, 15));
      return {nib, 28'($urandom)};
   endfunction

   function automatic logic [7:0] random_length();
      if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, 8));
      return 8'($urandom_range(9, 255));
   endfunction

   task automatic test_message_frames();
      send_frame(make_frame(32'h0000_0000, 8'd0, 64'h0));
      send_frame(make_frame(32'h0FFF_FFFF, 8'd8, 64'hFFFF_FFFF_FFFF_FFFF));
      send_frame(make_frame(32'h0A12_3456, 8'd3, 64'h8877_6655_4433_2211));
   endtask

   task automatic test_signal_frames();
      send_frame(make_frame(32'h1000_0000, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF));
      send_frame(make_frame(32'h1FFF_FFFF, 8'd8, 64'h0123_4567_89AB_CDEF));
      send_frame(make_frame(32'h1ABC_D123, 8'd5, 64'hFFFF_FFFF_FFFF_FFFF));
   endtask

   task automatic test_long_length();
      send_frame(make_frame(32'h0321_0FED, 8'd9, 64'hA5A5_5A5A_C3C3_3C3C));
      send_frame(make_frame(32'h1234_5678, 8'd255, 64'hFEDC_BA98_7654_3210));
   endtask

   task automatic test_other_nibbles();
      send_frame(make_frame(32'h2000_0001, 8'd4, 64'h1111_2222_3333_4444));
      send_frame(make_frame(32'hFFFF_FFFF, 8'd8, 64'hFFFF_FFFF_FFFF_FFFF));
   endtask

   task automatic test_header_mismatch();
      frame_type f;
      for (int k = 1; k <= 4; k++) begin
         f = make_frame(32'h0111_2222, 8'd2, 64'h0000_0000_0000_BEEF);
         f[k] = f[k] ^ 8'h40;
         send_frame(f);
      end
      // a repeated sync byte is not taken as a new start
      send_byte(HDR_BYTE0);
      send_frame(make_frame(32'h0555_6666, 8'd1, 64'h77));
      send_frame(make_frame(32'h1777_8888, 8'd6, 64'h0000_6655_4433_2211));
   endtask

   task automatic test_pad_and_checksum();
      frame_type f;
      f = make_frame(32'h0999_AAAA, 8'd8, 64'h1234_1234_1234_1234);
      f[18] = 8'h80;
      send_frame(f);
      f = make_frame(32'h1999_AAAA, 8'd7, 64'h4321_4321_4321_4321);
      f[19] = f[19] ^ 8'h01;
      send_frame(f);
      send_frame(make_frame(32'h0BBB_CCCC, 8'd8, 64'h0F0F_0F0F_0F0F_0F0F));
   endtask

   task automatic test_hunting_noise();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HDR_BYTE1);
      send_byte(HDR_BYTE2);
      send_frame(make_frame(32'h1DEF_0123, 8'd2, 64'h0000_0000_0000_55AA));
   endtask

   task automatic test_long_stall();
      @(negedge clock);
      req_ch.valid  <= 1'b0;
      hold_requests <= hold_requests + 1;
      for (int k = 0; k < 3; k++) begin
         send_frame(make_frame(random_ident() & 32'h1FFF_FFFF, random_length(),
                               {$urandom, $urandom}));
      end
   endtask

   task automatic test_random_traffic(input int n_bytes, input int n_results);
      int        bytes_goal;
      int        results_goal;
      int        pick;
      int        k;
      frame_type f;
      bytes_goal = bytes_sent + n_bytes;
      results_goal = results_seen + n_results;
      while (bytes_sent < bytes_goal || results_seen < results_goal) begin
         pick = $urandom_range(0, 99);
         f = make_frame(random_ident(), random_length(), {$urandom, $urandom});
         if (pick < 70) begin
            send_frame(f);
         end else if (pick < 78) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 84) begin
            k = $urandom_range(1, 4);
            f[k] = f[k] ^ 8'($urandom_range(1, 255));
            send_frame(f);
         end else if (pick < 88) begin
            f[18] = 8'($urandom_range(1, 255));
            send_frame(f);
         end else if (pick < 94) begin
            f[19] = f[19] ^ 8'($urandom_range(1, 255));
            send_frame(f);
         end else begin
            k = $urandom_range(1, 19);
            for (int j = 0; j < k; j++) send_byte(f[j]);
         end
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      test_message_frames();
      test_signal_frames();
      test_long_length();
      test_other_nibbles();
      test_header_mismatch();
      test_pad_and_checksum();
      test_hunting_noise();
      test_long_stall();
      test_random_traffic(250, 6);

      // quiet tail
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      test_random_traffic(100, 2);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS can_adapter_frame_parser");
      end else begin
         $display("FAIL can_adapter_frame_parser");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cafp_pkg.sv
rtl/core/cafp_if.sv
rtl/core/cafp_decode.sv
rtl/core/can_adapter_frame_parser.sv
verif/can_adapter_frame_parser_tb.sv
